@@ rtl/core/idv_pkg.sv @@
`default_nettype none

package idv_pkg;

  // byte codes that steer the scan
  localparam logic [7:0] CHAR_AT         = 8'h40;
  localparam logic [7:0] CHAR_DOT        = 8'h2E;
  localparam logic [7:0] CHAR_DASH       = 8'h2D;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

  // tag of each byte
  localparam logic [1:0] PART_NAME   = 2'd0;
  localparam logic [1:0] PART_SEP    = 2'd1;
  localparam logic [1:0] PART_DOMAIN = 2'd2;

  // configuration register indexes
  localparam logic REG_NAME_BUF   = 1'b0;
  localparam logic REG_DOMAIN_BUF = 1'b1;

  localparam int NAME_BUF_W   = 7;
  localparam int DOMAIN_BUF_W = 9;

  localparam logic [NAME_BUF_W-1:0]   NAME_BUF_RESET   = 7'd65;
  localparam logic [DOMAIN_BUF_W-1:0] DOMAIN_BUF_RESET = 9'd257;

  // smallest buffers that can hold a usable identifier
  localparam logic [NAME_BUF_W-1:0]   MIN_NAME_BUF   = 7'd2;
  localparam logic [DOMAIN_BUF_W-1:0] MIN_DOMAIN_BUF = 9'd4;

  typedef struct packed {
    logic [7:0] out_char;
    logic [1:0] char_part;
    logic       done_res;
    logic       status;
  } result_t;

  function automatic logic is_alnum(input logic [7:0] c);
    is_alnum = (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]});
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    to_lower = (c inside {[8'h41:8'h5A]}) ? (c | 8'h20) : c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/idv_scan.sv @@
`default_nettype none

module idv_scan #(
  parameter int MAX_NAME   = 64,
  parameter int MAX_DOMAIN = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             accept,
  input  wire logic [7:0]                       char_in,
  input  wire logic                             last,
  input  wire logic [idv_pkg::NAME_BUF_W-1:0]   name_buffer_size,
  input  wire logic [idv_pkg::DOMAIN_BUF_W-1:0] domain_buffer_size,
  output idv_pkg::result_t                      result
);
  import idv_pkg::*;

  // counters saturate at their limit plus one
  localparam int NW  = $clog2(MAX_NAME + 2);
  localparam int DW  = $clog2(MAX_DOMAIN + 2);
  localparam int NCW = (NW > NAME_BUF_W) ? NW : NAME_BUF_W;
  localparam int DCW = (DW > DOMAIN_BUF_W) ? DW : DOMAIN_BUF_W;

  logic          in_domain, in_domain_next;
  logic [NW-1:0] name_count, name_count_next;
  logic [DW-1:0] domain_count, domain_count_next;
  logic          previous_was_dot, previous_was_dot_next;
  logic          domain_has_dot, domain_has_dot_next;
  logic          error_seen, error_seen_next;
  logic [1:0]    part;
  logic          bad;

  always_comb begin
    in_domain_next        = in_domain;
    name_count_next       = name_count;
    domain_count_next     = domain_count;
    previous_was_dot_next = previous_was_dot;
    domain_has_dot_next   = domain_has_dot;
    error_seen_next       = error_seen;
    if (!in_domain) begin
      if (char_in == CHAR_AT) begin
        in_domain_next = 1'b1;
        part           = PART_SEP;
      end else begin
        part = PART_NAME;
        if (!(is_alnum(char_in) || char_in == CHAR_DASH ||
              char_in == CHAR_UNDERSCORE || char_in == CHAR_DOT)) begin
          error_seen_next = 1'b1;
        end
        if (name_count <= NW'(MAX_NAME)) begin
          name_count_next = name_count + 1'b1;
        end
      end
    end else begin
      part = PART_DOMAIN;
      if (char_in == CHAR_DOT) begin
        // leading or doubled dot
        if (domain_count == '0 || previous_was_dot) begin
          error_seen_next = 1'b1;
        end
        domain_has_dot_next   = 1'b1;
        previous_was_dot_next = 1'b1;
      end else begin
        if (!(is_alnum(char_in) || char_in == CHAR_DASH)) begin
          error_seen_next = 1'b1;
        end
        previous_was_dot_next = 1'b0;
      end
      if (domain_count <= DW'(MAX_DOMAIN)) begin
        domain_count_next = domain_count + 1'b1;
      end
    end

    bad = error_seen_next || !in_domain_next
       || name_count_next == '0 || name_count_next > NW'(MAX_NAME)
       || domain_count_next == '0 || domain_count_next > DW'(MAX_DOMAIN)
       || !domain_has_dot_next || previous_was_dot_next
       || name_buffer_size < MIN_NAME_BUF
       || domain_buffer_size < MIN_DOMAIN_BUF
       || NCW'(name_count_next) >= NCW'(name_buffer_size)
       || DCW'(domain_count_next) >= DCW'(domain_buffer_size);

    result.out_char  = to_lower(char_in);
    result.char_part = part;
    result.done_res  = last;
    result.status    = last & bad;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      in_domain        <= 1'b0;
      name_count       <= '0;
      domain_count     <= '0;
      previous_was_dot <= 1'b0;
      domain_has_dot   <= 1'b0;
      error_seen       <= 1'b0;
    end else if (accept) begin
      in_domain        <= in_domain_next;
      name_count       <= name_count_next;
      domain_count     <= domain_count_next;
      previous_was_dot <= previous_was_dot_next;
      domain_has_dot   <= domain_has_dot_next;
      error_seen       <= error_seen_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/identifier_name_domain_validator.sv @@
`default_nettype none

// identifier validator: takes a name@domain identifier one byte per
// transaction on the char channel (last marks the final byte) and returns one
// result transaction per byte on the res channel, with the byte lowercased,
// tagged as name, separator or domain, and on the final byte a status of
// 0 for valid or 1 for invalid. a byte can be taken in every cycle while
// char_stall is low. the scan state updates in the accepting cycle and the
// result lands in a two-entry output buffer (output register plus skid
// register), so char_stall rises only when both entries are full. buffer size
// registers are written through wr_en/wr_index/wr_data and take effect on
// the next final byte.
module identifier_name_domain_validator #(
  parameter int MAX_NAME   = 64,
  parameter int MAX_DOMAIN = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration write port
  input  wire logic                             wr_en,
  input  wire logic                             wr_index,
  input  wire logic [idv_pkg::DOMAIN_BUF_W-1:0] wr_data,
  // byte channel
  input  wire logic                             char_valid,
  output logic                                  char_stall,
  input  wire logic [7:0]                       char_in,
  input  wire logic                             last,
  // result channel
  output logic                                  res_valid,
  input  wire logic                             res_stall,
  output logic [7:0]                            out_char,
  output logic [1:0]                            char_part,
  output logic                                  done_res,
  output logic                                  status
);
  import idv_pkg::*;

  logic [NAME_BUF_W-1:0]   name_buffer_size;
  logic [DOMAIN_BUF_W-1:0] domain_buffer_size;

  logic    accept;
  logic    take;
  result_t scan_result;
  result_t out_reg;
  result_t skid_reg;
  logic    skid_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      name_buffer_size   <= NAME_BUF_RESET;
      domain_buffer_size <= DOMAIN_BUF_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_NAME_BUF:   name_buffer_size   <= wr_data[NAME_BUF_W-1:0];
        REG_DOMAIN_BUF: domain_buffer_size <= wr_data;
        default: ;
      endcase
    end
  end

  // the skid register absorbs one transaction while the output is stalled
  assign char_stall = skid_valid;
  assign accept     = char_valid && !char_stall;
  assign take       = res_valid && !res_stall;

  idv_scan #(
    .MAX_NAME   (MAX_NAME),
    .MAX_DOMAIN (MAX_DOMAIN)
  ) u_scan (
    .clk                (clk),
    .rst                (rst),
    .accept             (accept),
    .char_in            (char_in),
    .last               (last),
    .name_buffer_size   (name_buffer_size),
    .domain_buffer_size (domain_buffer_size),
    .result             (scan_result)
  );

  // output register and skid control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // no accept while the skid entry is full
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!res_valid || take) begin
        res_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      res_valid <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_reg <= skid_reg;
      end
    end else if (accept) begin
      if (!res_valid || take) begin
        out_reg <= scan_result;
      end else begin
        skid_reg <= scan_result;
      end
    end
  end

  assign out_char  = out_reg.out_char;
  assign char_part = out_reg.char_part;
  assign done_res  = out_reg.done_res;
  assign status    = out_reg.status;

  // skid entry is only used behind a full output register
  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid entry full while output register empty");

  // a transaction accepted into a stalled full output must land in the skid
  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    (accept && res_valid && res_stall) |=> skid_valid)
    else $error("transaction accepted under stall was not buffered");

  // status is only raised on the final byte
  a_status_on_done: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !done_res) |-> !status)
    else $error("status set on a byte that is not final");

endmodule

`default_nettype wire
